// ===== design/lutqdp_pkg.sv =====
// ---------------------------------------------------------------------------
// lutqdp_pkg
// Shared constants, codes and types of the lookup-table dot-product engine.
// ---------------------------------------------------------------------------
`default_nettype none

package lutqdp_pkg;

   // table geometry and element limit
   localparam int MAX_CODE_BITS = 8;
   localparam int ENTRY_WIDTH   = 16;
   localparam int MAX_ELEMENTS  = 4096;
   localparam int ADDR_W        = 2 * MAX_CODE_BITS;
   localparam int TABLE_DEPTH   = 1 << ADDR_W;
   localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);

   // field widths fixed by the interface
   localparam int CODE_BITS_W = 4;
   localparam int ACC_W       = 32;
   localparam int REAL_W      = 32;
   localparam int ROWSUM_W    = 40;
   localparam int RES_W       = 48;
   localparam int FRAC_W      = 16;
   localparam int IDX_W       = 16;
   localparam int WORD_W      = 16;
   localparam int ACT_W       = 8;
   localparam int CSR_IDX_W   = 3;

   // width of the exact Q52.32 sum before rounding
   localparam int SUM_W = 84;

   // item function codes
   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_MULTIPLY = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CODE_BITS         = 3'd0,
      REG_FILTER_OFFSET     = 3'd1,
      REG_FILTER_INV_SCALE  = 3'd2,
      REG_SCALE_PRODUCT     = 3'd3,
      REG_ACT_SUM_WEIGHT    = 3'd4,
      REG_FILTER_SUM_WEIGHT = 3'd5,
      REG_OFFSET_PRODUCT    = 3'd6
   } csr_reg_type;

endpackage

`default_nettype wire

// ===== design/lut_approx_quantized_dot_product.sv =====
// ---------------------------------------------------------------------------
// lut_approx_quantized_dot_product
// Approximate quantized dot product: quantizes filter values, looks up
// products in a table memory, accumulates and applies the offset correction.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | func, table_index, table_word,
//          |           |                      | act_code, filter_value,
//          |           |                      | act_sum, filter_sum, last
//  rsp     | out       | rsp_valid/rsp_ready  | result, overflow
//  csr     | in        | csr_write_enable     | csr_index, csr_wdata
//
//  one item is taken per cycle unless the pipeline holds; the single-port
//  product table sees one access per item (write for a load, read for a
//  multiply) and sets that rate. a last item passes stages a to h, then the
//  output register. reset clears valids, accumulator, element count, sticky
//  flag, resets csrs to defaults; table not cleared, needs no clearing pass.
//  the whole pipeline holds only when a finished result in the final stage
//  cannot move into a still occupied, stalled output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lut_approx_quantized_dot_product
   import lutqdp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // item channel
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_func,
   input  wire logic [IDX_W-1:0]           req_table_index,
   input  wire logic [WORD_W-1:0]          req_table_word,
   input  wire logic [ACT_W-1:0]           req_act_code,
   input  wire logic signed [REAL_W-1:0]   req_filter_value,
   input  wire logic signed [ROWSUM_W-1:0] req_act_sum,
   input  wire logic signed [ROWSUM_W-1:0] req_filter_sum,
   input  wire logic                       req_last,
   // result channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic signed [RES_W-1:0]    rsp_result,
   output      logic                       rsp_overflow,
   // configuration
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [REAL_W-1:0]          csr_wdata
);

   localparam int CB_W = $clog2(MAX_CODE_BITS + 1);

   // configuration registers
   logic [CODE_BITS_W-1:0]     code_bits_ff;
   logic signed [REAL_W-1:0]   filter_offset_ff;
   logic [REAL_W-1:0]          filter_inv_scale_ff;
   logic signed [REAL_W-1:0]   scale_product_ff;
   logic signed [REAL_W-1:0]   act_sum_weight_ff;
   logic signed [REAL_W-1:0]   filter_sum_weight_ff;
   logic signed [REAL_W-1:0]   offset_product_ff;

   // pipeline control
   logic advance;
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic e_valid_ff, f_valid_ff, g_valid_ff;
   logic rsp_valid_ff;

   // item payload through the front stages
   logic                       a_func_ff, b_func_ff, c_func_ff, d_func_ff;
   logic                       a_last_ff, b_last_ff, c_last_ff, d_last_ff;
   logic [ACT_W-1:0]           a_act_ff, b_act_ff, c_act_ff;
   logic [IDX_W-1:0]           a_index_ff, b_index_ff, c_index_ff;
   logic [ENTRY_WIDTH-1:0]     a_word_ff, b_word_ff, c_word_ff;
   logic signed [ROWSUM_W-1:0] a_asum_ff, b_asum_ff, c_asum_ff, d_asum_ff;
   logic signed [ROWSUM_W-1:0] a_fsum_ff, b_fsum_ff, c_fsum_ff, d_fsum_ff;
   logic signed [REAL_W:0]     a_diff_in, a_diff_ff;
   logic                       b_pos_ff, c_pos_ff;
   logic [2*REAL_W-1:0]        b_prod_ff;

   // quantization and table access
   logic [CB_W-1:0]            code_bits_eff;
   logic [MAX_CODE_BITS-1:0]   max_code;
   logic [ADDR_W-1:0]          c_addr;
   logic                       mem_write;
   logic                       mem_read;
   logic [ENTRY_WIDTH-1:0]     product_table [TABLE_DEPTH];
   logic [ENTRY_WIDTH-1:0]     rd_word_ff;

   // accumulation state
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       sticky_ff, sticky_in;
   logic [ACC_W:0]             acc_sum;
   logic                       d_step;
   logic                       d_close;

   // correction stages
   logic [ACC_W-1:0]           e_acc_ff;
   logic [CNT_W-1:0]           e_cnt_ff;
   logic                       e_sticky_ff, f_sticky_ff, g_sticky_ff;
   logic signed [ROWSUM_W-1:0] e_asum_ff, e_fsum_ff;
   logic signed [ACC_W+REAL_W:0]            f_pacc_ff;
   logic signed [REAL_W+ROWSUM_W-FRAC_W-1:0] f_ahi_ff, f_fhi_ff;
   logic signed [REAL_W+FRAC_W:0]           f_alo_ff, f_flo_ff;
   logic signed [CNT_W+REAL_W:0]            f_pcnt_ff;
   logic signed [SUM_W-1:0]    g_base_ff, g_aterm_ff, g_fterm_ff;
   logic signed [SUM_W-1:0]    sum_in, sum_ff;
   logic                       h_valid_ff;
   logic                       h_sticky_ff;

   // saturation of the rounded sum
   logic [SUM_W-RES_W-FRAC_W:0] sum_top;
   logic                        sum_fits;
   logic signed [RES_W-1:0]     sat_result;

   // -------------------------------------------------------------------------
   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff         <= CODE_BITS_W'(MAX_CODE_BITS);
         filter_offset_ff     <= '0;
         filter_inv_scale_ff  <= REAL_W'(1 << FRAC_W);
         scale_product_ff     <= REAL_W'(1 << FRAC_W);
         act_sum_weight_ff    <= '0;
         filter_sum_weight_ff <= '0;
         offset_product_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CODE_BITS:         code_bits_ff         <= csr_wdata[CODE_BITS_W-1:0];
            REG_FILTER_OFFSET:     filter_offset_ff     <= csr_wdata;
            REG_FILTER_INV_SCALE:  filter_inv_scale_ff  <= csr_wdata;
            REG_SCALE_PRODUCT:     scale_product_ff     <= csr_wdata;
            REG_ACT_SUM_WEIGHT:    act_sum_weight_ff    <= csr_wdata;
            REG_FILTER_SUM_WEIGHT: filter_sum_weight_ff <= csr_wdata;
            REG_OFFSET_PRODUCT:    offset_product_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // pipeline holds only when a result is blocked at the output register
   assign advance   = !(h_valid_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_close;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   // -------------------------------------------------------------------------
   // stage a: capture the transfer and subtract the filter offset
   assign a_diff_in = (REAL_W+1)'(req_filter_value) - (REAL_W+1)'(filter_offset_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         a_func_ff  <= req_func;
         a_last_ff  <= req_last;
         a_act_ff   <= req_act_code;
         a_index_ff <= req_table_index;
         a_word_ff  <= ENTRY_WIDTH'(req_table_word);
         a_asum_ff  <= req_act_sum;
         a_fsum_ff  <= req_filter_sum;
         a_diff_ff  <= a_diff_in;
      end
   end

   // stage b: scale the positive difference by the inverse scale
   always_ff @(posedge clock) begin
      if (advance) begin
         b_func_ff  <= a_func_ff;
         b_last_ff  <= a_last_ff;
         b_act_ff   <= a_act_ff;
         b_index_ff <= a_index_ff;
         b_word_ff  <= a_word_ff;
         b_asum_ff  <= a_asum_ff;
         b_fsum_ff  <= a_fsum_ff;
         b_pos_ff   <= !a_diff_ff[REAL_W] && (a_diff_ff != '0);
         b_prod_ff  <= a_diff_ff[REAL_W-1:0] * filter_inv_scale_ff;
      end
   end

   // stage c: round half up, saturate the code, form the table address
   always_comb begin
      priority if (code_bits_ff == '0)
         code_bits_eff = CB_W'(1);
      else if (code_bits_ff > CODE_BITS_W'(MAX_CODE_BITS))
         code_bits_eff = CB_W'(MAX_CODE_BITS);
      else
         code_bits_eff = CB_W'(code_bits_ff);
   end

   assign max_code    = MAX_CODE_BITS'((MAX_CODE_BITS+1)'(1) << code_bits_eff) - 1'b1;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_func_ff  <= b_func_ff;
         c_last_ff  <= b_last_ff;
         c_act_ff   <= b_act_ff;
         c_index_ff <= b_index_ff;
         c_word_ff  <= b_word_ff;
         c_asum_ff  <= b_asum_ff;
         c_fsum_ff  <= b_fsum_ff;
         c_pos_ff   <= b_pos_ff;
      end
   end

   // product register for the stage c rounding
   logic [2*REAL_W-1:0] c_prod_ff;
   logic [2*REAL_W:0]   c_round_sum;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_prod_ff <= b_prod_ff;
      end
   end

   assign c_round_sum = (2*REAL_W+1)'(c_prod_ff) + (2*REAL_W+1)'(64'h8000_0000);

   logic [REAL_W:0]          c_qcode_wide;
   logic [MAX_CODE_BITS-1:0] c_qcode;

   assign c_qcode_wide = c_round_sum[2*REAL_W:REAL_W];

   always_comb begin
      priority if (!c_pos_ff)
         c_qcode = '0;
      else if (c_qcode_wide > (REAL_W+1)'(max_code))
         c_qcode = max_code;
      else
         c_qcode = c_qcode_wide[MAX_CODE_BITS-1:0];
   end

   // table address: activation code above the filter code for a multiply, table index for a load
   always_comb begin
      if (c_func_ff == FUNC_MULTIPLY)
         c_addr = (ADDR_W'(c_act_ff) << code_bits_eff) | ADDR_W'(c_qcode);
      else
         c_addr = c_index_ff[ADDR_W-1:0];
   end

   // -------------------------------------------------------------------------
   // product table: one access per item, in item order
   assign mem_write = advance && c_valid_ff && (c_func_ff == FUNC_LOAD);
   assign mem_read  = advance && c_valid_ff && (c_func_ff == FUNC_MULTIPLY);

   always_ff @(posedge clock) begin
      if (mem_write)
         product_table[c_addr] <= c_word_ff;
      if (mem_read)
         rd_word_ff <= product_table[c_addr];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_func_ff <= c_func_ff;
         d_last_ff <= c_last_ff;
         d_asum_ff <= c_asum_ff;
         d_fsum_ff <= c_fsum_ff;
      end
   end

   // -------------------------------------------------------------------------
   // stage d: saturating accumulate, element count, closing of a dot product
   assign d_step  = advance && d_valid_ff && (d_func_ff == FUNC_MULTIPLY);
   assign d_close = d_valid_ff && (d_func_ff == FUNC_MULTIPLY) && d_last_ff;
   assign acc_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(rd_word_ff);

   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      sticky_in = sticky_ff;
      if (d_step) begin
         if (acc_sum[ACC_W]) begin
            acc_in    = '1;
            sticky_in = 1'b1;
         end else begin
            acc_in = acc_sum[ACC_W-1:0];
         end
         if (cnt_ff >= CNT_W'(MAX_ELEMENTS))
            sticky_in = 1'b1;
         else
            cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         sticky_ff <= 1'b0;
      end else if (d_step && d_last_ff) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         sticky_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         sticky_ff <= sticky_in;
      end
   end

   // stage e: closing totals
   always_ff @(posedge clock) begin
      if (advance) begin
         e_acc_ff    <= acc_in;
         e_cnt_ff    <= cnt_in;
         e_sticky_ff <= sticky_in;
         e_asum_ff   <= d_asum_ff;
         e_fsum_ff   <= d_fsum_ff;
      end
   end

   // stage f: weight products, row sums split into high and low partials
   always_ff @(posedge clock) begin
      if (advance) begin
         f_sticky_ff <= e_sticky_ff;
         f_pacc_ff   <= $signed({1'b0, e_acc_ff}) * scale_product_ff;
         f_ahi_ff    <= act_sum_weight_ff * $signed(e_asum_ff[ROWSUM_W-1:FRAC_W]);
         f_alo_ff    <= act_sum_weight_ff * $signed({1'b0, e_asum_ff[FRAC_W-1:0]});
         f_fhi_ff    <= filter_sum_weight_ff * $signed(e_fsum_ff[ROWSUM_W-1:FRAC_W]);
         f_flo_ff    <= filter_sum_weight_ff * $signed({1'b0, e_fsum_ff[FRAC_W-1:0]});
         f_pcnt_ff   <= $signed({1'b0, e_cnt_ff}) * offset_product_ff;
      end
   end

   // stage g: bring every term to Q52.32
   always_ff @(posedge clock) begin
      if (advance) begin
         g_sticky_ff <= f_sticky_ff;
         g_base_ff   <= (SUM_W'(f_pacc_ff) <<< FRAC_W) - (SUM_W'(f_pcnt_ff) <<< FRAC_W);
         g_aterm_ff  <= (SUM_W'(f_ahi_ff) <<< FRAC_W) + SUM_W'(f_alo_ff);
         g_fterm_ff  <= (SUM_W'(f_fhi_ff) <<< FRAC_W) + SUM_W'(f_flo_ff);
      end
   end

   // stage h: total plus one half for rounding
   assign sum_in = g_base_ff + g_aterm_ff + g_fterm_ff + SUM_W'(1 << (FRAC_W - 1));

   always_ff @(posedge clock) begin
      if (advance) begin
         h_sticky_ff <= g_sticky_ff;
         sum_ff      <= sum_in;
      end
   end

   // -------------------------------------------------------------------------
   // drop the fraction bits and saturate to the result range
   assign sum_top  = sum_ff[SUM_W-1:RES_W+FRAC_W-1];
   assign sum_fits = (&sum_top) || !(|sum_top);

   always_comb begin
      if (sum_fits)
         sat_result = sum_ff[RES_W+FRAC_W-1:FRAC_W];
      else if (sum_ff[SUM_W-1])
         sat_result = {1'b1, {(RES_W-1){1'b0}}};
      else
         sat_result = {1'b0, {(RES_W-1){1'b1}}};
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (h_valid_ff && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (h_valid_ff && advance) begin
         rsp_result   <= sat_result;
         rsp_overflow <= h_sticky_ff || !sum_fits;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // element count never passes its limit
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above limit");

   // a closing multiply leaves a cleared accumulator and counter behind
   assert property (@(posedge clock) disable iff (reset)
      (d_step && d_last_ff) |=> (acc_ff == '0 && cnt_ff == '0 && !sticky_ff))
      else $error("dot-product state not cleared after last element");

   // a result held back by the stall is not lost or altered
   assert property (@(posedge clock) disable iff (reset)
      (h_valid_ff && !advance) |=> (h_valid_ff && $stable(sum_ff)))
      else $error("final stage changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/lutqdp_dot_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lutqdp_dot_checker
// Watches the item, result and csr ports of the lookup-table dot-product
// engine. Keeps its own product table, accumulator, element counter and csr
// copies, predicts every finished dot product and compares it, field by
// field, with the result that leaves the engine.
// ---------------------------------------------------------------------------
module lutqdp_dot_checker
   import lutqdp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // item channel
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_func,
   input  logic [IDX_W-1:0]           req_table_index,
   input  logic [WORD_W-1:0]          req_table_word,
   input  logic [ACT_W-1:0]           req_act_code,
   input  logic [REAL_W-1:0]          req_filter_value,
   input  logic signed [ROWSUM_W-1:0] req_act_sum,
   input  logic signed [ROWSUM_W-1:0] req_filter_sum,
   input  logic                       req_last,
   // result channel
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [RES_W-1:0]    rsp_result,
   input  logic                       rsp_overflow,
   // configuration
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [REAL_W-1:0]          csr_wdata,
   // status for the stimulus side
   output int                         failures,
   output int                         pending
);

   localparam logic signed [127:0] RES_HI = (128'sd1 <<< (RES_W - 1)) - 128'sd1;
   localparam logic signed [127:0] RES_LO = -(128'sd1 <<< (RES_W - 1));

   typedef struct {
      logic signed [RES_W-1:0] result;
      logic                    overflow;
   } dot_result_type;

   // predicted engine state
   logic [WORD_W-1:0]      lut_words [TABLE_DEPTH];
   logic [ACC_W-1:0]       acc_total;
   logic [CNT_W-1:0]       elem_count;
   logic                   sticky_ovf;

   // csr copies
   logic [CODE_BITS_W-1:0] cfg_code_bits;
   logic [REAL_W-1:0]      cfg_offset;
   logic [REAL_W-1:0]      cfg_inv_scale;
   logic [REAL_W-1:0]      cfg_scale_product;
   logic [REAL_W-1:0]      cfg_act_weight;
   logic [REAL_W-1:0]      cfg_filter_weight;
   logic [REAL_W-1:0]      cfg_offset_product;

   dot_result_type dot_results_q [$];

   // table slot: activation code above the rounded, clamped filter code
   function automatic logic [ADDR_W-1:0] lut_slot(input logic [ACT_W-1:0] act,
                                                  input logic [REAL_W-1:0] fv);
      int                      bits;
      logic signed [REAL_W:0]  diff;
      logic [79:0]             code;
      logic [ADDR_W-1:0]       slot;
      bits = (cfg_code_bits == 0) ? 1 :
             (cfg_code_bits > MAX_CODE_BITS) ? MAX_CODE_BITS : cfg_code_bits;
      diff = $signed({fv[REAL_W-1], fv}) - $signed({cfg_offset[REAL_W-1], cfg_offset});
      code = '0;
      if (diff > 0)
         code = ({48'd0, diff[REAL_W-1:0]} * {48'd0, cfg_inv_scale} + (80'd1 << 31)) >> 32;
      if (code > (80'd1 << bits) - 80'd1)
         code = (80'd1 << bits) - 80'd1;
      slot = ({8'd0, act} << bits) | code[ADDR_W-1:0];
      return slot;
   endfunction

   // corrected dot product, exact in Q96.32, rounded and saturated to Q32.16
   function automatic dot_result_type corrected_sum(
                                         input logic signed [ROWSUM_W-1:0] act_sum,
                                         input logic signed [ROWSUM_W-1:0] flt_sum);
      logic signed [127:0] total, accx, cntx, scale, aw, fw, op, asx, fsx;
      dot_result_type      r;
      accx  = {96'd0, acc_total};
      cntx  = {{(128-CNT_W){1'b0}}, elem_count};
      scale = {{96{cfg_scale_product[31]}}, cfg_scale_product};
      aw    = {{96{cfg_act_weight[31]}}, cfg_act_weight};
      fw    = {{96{cfg_filter_weight[31]}}, cfg_filter_weight};
      op    = {{96{cfg_offset_product[31]}}, cfg_offset_product};
      asx   = {{(128-ROWSUM_W){act_sum[ROWSUM_W-1]}}, act_sum};
      fsx   = {{(128-ROWSUM_W){flt_sum[ROWSUM_W-1]}}, flt_sum};
      total = ((accx * scale) <<< 16) + aw * asx + fw * fsx - ((cntx * op) <<< 16);
      total = (total + 128'sd32768) >>> 16;
      r.overflow = sticky_ovf;
      if (total > RES_HI) begin
         total      = RES_HI;
         r.overflow = 1'b1;
      end else if (total < RES_LO) begin
         total      = RES_LO;
         r.overflow = 1'b1;
      end
      r.result = total[RES_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      logic [ACC_W:0]    acc_next;
      logic [ADDR_W-1:0] slot;
      dot_result_type    want;
      int                errs;
      errs = 0;
      if (reset) begin
         acc_total          = '0;
         elem_count         = '0;
         sticky_ovf         = 1'b0;
         cfg_code_bits      = 4'd8;
         cfg_offset         = '0;
         cfg_inv_scale      = 32'h0001_0000;
         cfg_scale_product  = 32'h0001_0000;
         cfg_act_weight     = '0;
         cfg_filter_weight  = '0;
         cfg_offset_product = '0;
         dot_results_q.delete();
         failures <= 0;
         pending  <= 0;
      end else begin
         // csr writes
         if (csr_write_enable) begin
            case (csr_reg_type'(csr_index))
               REG_CODE_BITS:         cfg_code_bits      = csr_wdata[CODE_BITS_W-1:0];
               REG_FILTER_OFFSET:     cfg_offset         = csr_wdata;
               REG_FILTER_INV_SCALE:  cfg_inv_scale      = csr_wdata;
               REG_SCALE_PRODUCT:     cfg_scale_product  = csr_wdata;
               REG_ACT_SUM_WEIGHT:    cfg_act_weight     = csr_wdata;
               REG_FILTER_SUM_WEIGHT: cfg_filter_weight  = csr_wdata;
               REG_OFFSET_PRODUCT:    cfg_offset_product = csr_wdata;
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (dot_results_q.size() == 0) begin
               $error("result: expected none, actual %0d", rsp_result);
               errs++;
            end else begin
               want = dot_results_q.pop_front();
               if (rsp_result !== want.result) begin
                  $error("result: expected %0d, actual %0d", want.result, rsp_result);
                  errs++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0d, actual %0d", want.overflow, rsp_overflow);
                  errs++;
               end
            end
         end

         // item transfer
         if (req_valid && req_ready) begin
            if (req_func == FUNC_LOAD) begin
               lut_words[req_table_index] = req_table_word;
            end else begin
               slot     = lut_slot(req_act_code, req_filter_value);
               acc_next = {1'b0, acc_total} + lut_words[slot];
               if (acc_next[ACC_W]) begin
                  acc_total  = '1;
                  sticky_ovf = 1'b1;
               end else begin
                  acc_total = acc_next[ACC_W-1:0];
               end
               // the counter sticks at the element limit
               if (elem_count >= MAX_ELEMENTS)
                  sticky_ovf = 1'b1;
               else
                  elem_count = elem_count + 1'b1;
               if (req_last) begin
                  dot_results_q.push_back(corrected_sum(req_act_sum, req_filter_sum));
                  acc_total  = '0;
                  elem_count = '0;
                  sticky_ovf = 1'b0;
               end
            end
         end

         failures <= failures + errs;
         pending  <= dot_results_q.size();
      end
   end

endmodule

// ===== verif/tb_lut_approx_quantized_dot_product.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lut_approx_quantized_dot_product
// Drives load and multiply items, csr settings and result-side stalls into
// the dot-product engine; the checker beside it predicts and compares.
// Multiplies only touch table slots that were loaded before.
// ---------------------------------------------------------------------------
module tb_lut_approx_quantized_dot_product;
   import lutqdp_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic                       req_func         = FUNC_LOAD;
   logic [IDX_W-1:0]           req_table_index  = '0;
   logic [WORD_W-1:0]          req_table_word   = '0;
   logic [ACT_W-1:0]           req_act_code     = '0;
   logic signed [REAL_W-1:0]   req_filter_value = '0;
   logic signed [ROWSUM_W-1:0] req_act_sum      = '0;
   logic signed [ROWSUM_W-1:0] req_filter_sum   = '0;
   logic                       req_last         = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [RES_W-1:0]    rsp_result;
   logic                       rsp_overflow;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index        = '0;
   logic [REAL_W-1:0]          csr_wdata        = '0;

   int failures;
   int pending;

   // quantizer settings as last written, used to find the slot a multiply reads
   logic [CODE_BITS_W-1:0] shadow_bits   = 4'd8;
   logic [REAL_W-1:0]      shadow_offset = '0;
   logic [REAL_W-1:0]      shadow_inv    = 32'h0001_0000;
   bit                     lut_loaded [TABLE_DEPTH];

   logic quiet       = 1'b0;
   int   holds_asked = 0;
   int   holds_done  = 0;
   int   hold_left   = 0;
   int   items_sent  = 0;
   int   idle_cycles = 0;

   always #5 clock = ~clock;

   lut_approx_quantized_dot_product DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_table_index  (req_table_index),
      .req_table_word   (req_table_word),
      .req_act_code     (req_act_code),
      .req_filter_value (req_filter_value),
      .req_act_sum      (req_act_sum),
      .req_filter_sum   (req_filter_sum),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_overflow     (rsp_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   lutqdp_dot_checker dot_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_table_index  (req_table_index),
      .req_table_word   (req_table_word),
      .req_act_code     (req_act_code),
      .req_filter_value (req_filter_value),
      .req_act_sum      (req_act_sum),
      .req_filter_sum   (req_filter_sum),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_overflow     (rsp_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending)
   );

   // result side: random stalls, or a long hold when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_asked;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 7);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // row sums: full range or a small signed value
   function automatic logic [ROWSUM_W-1:0] rand_row_sum();
      logic [63:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(1))
         return r[ROWSUM_W-1:0];
      return {{(ROWSUM_W-24){r[23]}}, r[23:0]};
   endfunction

   // filter values: full range or a spread just above the offset
   function automatic logic [REAL_W-1:0] rand_filter();
      if ($urandom_range(1))
         return $urandom;
      return shadow_offset + $urandom_range(0, 32'h0100_0000);
   endfunction

   function automatic logic [IDX_W-1:0] slot_of(input logic [ACT_W-1:0] act,
                                                input logic [REAL_W-1:0] fv);
      int                     bits;
      logic signed [REAL_W:0] diff;
      logic [79:0]            code;
      logic [IDX_W-1:0]       slot;
      bits = (shadow_bits == 0) ? 1 :
             (shadow_bits > MAX_CODE_BITS) ? MAX_CODE_BITS : shadow_bits;
      diff = $signed({fv[REAL_W-1], fv}) - $signed({shadow_offset[REAL_W-1], shadow_offset});
      code = '0;
      if (diff > 0)
         code = ({48'd0, diff[REAL_W-1:0]} * {48'd0, shadow_inv} + (80'd1 << 31)) >> 32;
      if (code > (80'd1 << bits) - 80'd1)
         code = (80'd1 << bits) - 80'd1;
      slot = ({8'd0, act} << bits) | code[IDX_W-1:0];
      return slot;
   endfunction

   // one item transfer, with an occasional gap ahead of it
   task automatic push_item(input logic func, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] word, input logic [ACT_W-1:0] act,
                            input logic [REAL_W-1:0] fv, input logic last);
      if (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_table_index  <= idx;
      req_table_word   <= word;
      req_act_code     <= act;
      req_filter_value <= fv;
      req_act_sum      <= rand_row_sum();
      req_filter_sum   <= rand_row_sum();
      req_last         <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_word(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word);
      push_item(FUNC_LOAD, idx, word, ACT_W'($urandom), $urandom, 1'($urandom_range(1)));
      lut_loaded[idx] = 1'b1;
   endtask

   // multiply item; its table slot gets loaded first if it never was
   task automatic multiply(input logic [ACT_W-1:0] act, input logic [REAL_W-1:0] fv,
                           input logic last);
      logic [IDX_W-1:0] slot;
      slot = slot_of(act, fv);
      if (!lut_loaded[slot])
         load_word(slot, WORD_W'($urandom));
      push_item(FUNC_MULTIPLY, IDX_W'($urandom), WORD_W'($urandom), act, fv, last);
   endtask

   // one dot product with random content and a few loads mixed in
   task automatic dot_product(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            load_word(IDX_W'($urandom), WORD_W'($urandom));
         multiply(ACT_W'($urandom), rand_filter(), i == len - 1);
      end
   endtask

   task automatic run_random(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at)
         dot_product($urandom_range(1, 12));
   endtask

   // wait for every outstanding result and for the pipeline to empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type r, input logic [REAL_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= r;
      csr_wdata        <= v;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] bits, input logic [31:0] offset,
                             input logic [31:0] inv, input logic [31:0] sp,
                             input logic [31:0] aw, input logic [31:0] fw,
                             input logic [31:0] op);
      drain();
      write_csr(REG_CODE_BITS, {28'd0, bits});
      write_csr(REG_FILTER_OFFSET, offset);
      write_csr(REG_FILTER_INV_SCALE, inv);
      write_csr(REG_SCALE_PRODUCT, sp);
      write_csr(REG_ACT_SUM_WEIGHT, aw);
      write_csr(REG_FILTER_SUM_WEIGHT, fw);
      write_csr(REG_OFFSET_PRODUCT, op);
      csr_write_enable <= 1'b0;
      shadow_bits   = bits;
      shadow_offset = offset;
      shadow_inv    = inv;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: unit scales, the table word comes out directly
      load_word(16'h0000, 16'h0000);
      load_word(16'hFFFF, 16'hFFFF);
      load_word(16'h0503, 16'h04D2);
      push_item(FUNC_LOAD, 16'h0503, 16'h04D2, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      multiply(8'h00, 32'h0000_0000, 1'b1);
      // filter code saturates at the top code
      multiply(8'hFF, 32'h7FFF_FFFF, 1'b1);
      multiply(8'h05, 32'h0003_0000, 1'b0);
      // 2.5 rounds half up to 3
      multiply(8'h05, 32'h0002_8000, 1'b0);
      // below the offset gives code 0
      multiply(8'h05, 32'h8000_0000, 1'b1);
      // just under one half rounds down
      multiply(8'h80, 32'h0000_7FFF, 1'b1);

      // extremes, code width 0 acts as 1
      set_config(4'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      multiply(8'hFF, 32'h7FFF_FFFF, 1'b1);
      multiply(8'h00, 32'h8000_0000, 1'b0);
      multiply(8'hAA, 32'h0000_0000, 1'b1);
      run_random(80);

      // moderate weights, no idling on either side
      set_config(4'd8, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000);
      quiet = 1'b1;
      run_random(80);
      quiet = 1'b0;

      // opposite extremes, code width above the limit acts as the limit
      set_config(4'd15, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      run_random(60);

      // long result-side hold while single-element dot products keep coming
      set_config(4'd4, 32'hFFFF_0000, 32'h0000_4000, 32'h0000_0100,
                 32'h0000_0010, 32'h0000_0020, 32'h0000_0001);
      holds_asked <= holds_asked + 1;
      repeat (40) dot_product(1);
      run_random(40);

      // random settings
      repeat (3) begin
         set_config(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
         run_random(40);
      end

      drain();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
